FILE: rtl/core/roq_pkg.sv
package roq_pkg;

  // Widths fixed by the item format.
  localparam int ENTRY_IDX_W = 6;
  localparam int FIELD_W     = 16;

  // Slots of the shared argument bundle that travels down the chain.
  // Write beats carry the rectangle, query beats carry the segment.
  localparam int RECT_LEFT   = 0;
  localparam int RECT_TOP    = 1;
  localparam int RECT_WIDTH  = 2;
  localparam int RECT_HEIGHT = 3;
  localparam int SEG_POS     = 0;
  localparam int SEG_START   = 1;
  localparam int SEG_END     = 2;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_WEST  = 3'd1,
    OP_EAST  = 3'd2,
    OP_SOUTH = 3'd3,
    OP_NORTH = 3'd4
  } op_e_t;

  // Control part of one beat as it moves from cell to cell.
  typedef struct packed {
    logic                   valid;
    op_e_t                  op;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   entry_present;
    logic                   rect_disabled;
    logic                   found;
  } roq_ctl_t;

endpackage

FILE: rtl/core/roq_cell.sv
module roq_cell
  import roq_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 6,
  parameter int CELL_ID    = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  roq_ctl_t                   in_ctl,
  input  logic [3:0][COORD_BITS-1:0] in_arg,
  input  logic [3:0][COORD_BITS-1:0] in_best,
  input  logic [IDX_W-1:0]           in_best_idx,
  output roq_ctl_t                   out_ctl,
  output logic [3:0][COORD_BITS-1:0] out_arg,
  output logic [3:0][COORD_BITS-1:0] out_best,
  output logic [IDX_W-1:0]           out_best_idx
);

  localparam int C = COORD_BITS;

  // Rectangle held by this cell, with its right and bottom edges kept ready.
  logic         present;
  logic         disabled;
  logic [C-1:0] left;
  logic [C-1:0] top;
  logic [C-1:0] width;
  logic [C-1:0] height;
  logic [C:0]   right;
  logic [C:0]   bottom;

  logic         wr_hit;
  logic [C:0]   pos;
  logic [C:0]   seg_s;
  logic [C:0]   seg_e;
  logic [C:0]   best_right;
  logic [C:0]   best_bottom;
  logic         blocks;
  logic         better;
  logic         take;
  roq_ctl_t     ctl_next;

  assign wr_hit = in_ctl.valid && (in_ctl.op == OP_WRITE)
                  && (32'(in_ctl.entry_index) == CELL_ID);

  assign pos         = {1'b0, in_arg[SEG_POS]};
  assign seg_s       = {1'b0, in_arg[SEG_START]};
  assign seg_e       = {1'b0, in_arg[SEG_END]};
  assign best_right  = {1'b0, in_best[RECT_LEFT]} + {1'b0, in_best[RECT_WIDTH]};
  assign best_bottom = {1'b0, in_best[RECT_TOP]} + {1'b0, in_best[RECT_HEIGHT]};

  // Blocking test and ranking against the best so far for each direction.
  always_comb begin
    blocks = 1'b0;
    better = 1'b0;
    unique case (in_ctl.op)
      OP_WEST: begin
        blocks = ({1'b0, left} < seg_s) && (right > seg_e)
                 && ({1'b0, top} < pos) && (bottom > pos);
        better = right > best_right;
      end
      OP_EAST: begin
        blocks = ({1'b0, left} < seg_e) && (right > seg_s)
                 && ({1'b0, top} < pos) && (bottom > pos);
        better = left < in_best[RECT_LEFT];
      end
      OP_SOUTH: begin
        blocks = (bottom > seg_s) && ({1'b0, top} < seg_e)
                 && ({1'b0, left} < pos) && (right > pos);
        better = top < in_best[RECT_TOP];
      end
      OP_NORTH: begin
        blocks = ({1'b0, top} < seg_s) && (bottom > seg_e)
                 && ({1'b0, left} < pos) && (right > pos);
        better = bottom > best_bottom;
      end
      default: begin
        blocks = 1'b0;
        better = 1'b0;
      end
    endcase
  end

  // Strictly better only, so the lowest slot keeps a tie.
  assign take = in_ctl.valid && present && !disabled && blocks
                && (!in_ctl.found || better);

  // Beat control handed to the next cell, with the found mark updated.
  always_comb begin
    ctl_next       = in_ctl;
    ctl_next.found = in_ctl.found || take;
  end

  // Present marks and beat control.
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      out_ctl <= '0;
    end else if (adv) begin
      if (wr_hit) begin
        present <= in_ctl.entry_present;
      end
      out_ctl <= ctl_next;
    end
  end

  // Stored rectangle and beat payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_hit && in_ctl.entry_present) begin
        disabled <= in_ctl.rect_disabled;
        left     <= in_arg[RECT_LEFT];
        top      <= in_arg[RECT_TOP];
        width    <= in_arg[RECT_WIDTH];
        height   <= in_arg[RECT_HEIGHT];
        right    <= {1'b0, in_arg[RECT_LEFT]} + {1'b0, in_arg[RECT_WIDTH]};
        bottom   <= {1'b0, in_arg[RECT_TOP]} + {1'b0, in_arg[RECT_HEIGHT]};
      end
      out_arg <= in_arg;
      if (take) begin
        out_best[RECT_LEFT]   <= left;
        out_best[RECT_TOP]    <= top;
        out_best[RECT_WIDTH]  <= width;
        out_best[RECT_HEIGHT] <= height;
        out_best_idx          <= IDX_W'(CELL_ID);
      end else begin
        out_best     <= in_best;
        out_best_idx <= in_best_idx;
      end
    end
  end

  // Only a query beat can carry a blocker.
  a_found_is_query: assert property (@(posedge clk) disable iff (rst)
    (out_ctl.valid && out_ctl.found) |->
      (out_ctl.op == OP_WEST || out_ctl.op == OP_EAST ||
       out_ctl.op == OP_SOUTH || out_ctl.op == OP_NORTH))
    else $error("found set on a beat that is not a query");

  // A blocker chosen here must be a live slot of this cell.
  a_own_pick_live: assert property (@(posedge clk) disable iff (rst)
    (out_ctl.valid && out_ctl.found && out_best_idx == IDX_W'(CELL_ID)) |->
      (present && !disabled))
    else $error("blocker picked from a slot that is absent or disabled");

  // Once a blocker is found, later cells never drop it.
  a_found_kept: assert property (@(posedge clk) disable iff (rst)
    (adv && in_ctl.valid && in_ctl.found) |=> out_ctl.found)
    else $error("found mark lost while passing a cell");

endmodule

FILE: rtl/core/rect_obstacle_query.sv
// Each accepted input beat passes through the register of every cell in turn to its result beat.
// Throughput: one item per cycle; every item walks the row of MAX_RECTS cells,
// one cell per cycle, and each cell holds and checks one table slot.
// The whole row stalls while a result beat waits on m_tready.
// Reset clears all present marks and the beats in flight; no clearing pass.
module rect_obstacle_query
  import roq_pkg::*;
#(
  parameter int MAX_RECTS  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index[5:0], entry_present[6], rect_disabled[7], rect_left[23:8],
  // rect_top[39:24], rect_width[55:40], rect_height[71:56], line_pos[87:72],
  // seg_start[103:88], seg_end[119:104]
  input  logic [119:0] s_tdata,
  // op[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_index[5:0], hit_left[21:6], hit_top[37:22], hit_width[53:38],
  // hit_height[69:54], zero fill[71:70]
  output logic [71:0]  m_tdata,
  // found[0]
  output logic [0:0]   m_tuser
);

  localparam int C     = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_RECTS);

  roq_ctl_t              ctl      [MAX_RECTS+1];
  logic [3:0][C-1:0]     arg      [MAX_RECTS+1];
  logic [3:0][C-1:0]     best     [MAX_RECTS+1];
  logic [IDX_W-1:0]      best_idx [MAX_RECTS+1];
  logic                  adv;
  logic                  is_write;

  // The row moves when the last cell's result is free or being taken.
  assign adv      = !ctl[MAX_RECTS].valid || m_tready;
  assign s_tready = adv;

  // Head of the row: unpack the input beat, no blocker yet.
  assign is_write = (s_tuser == OP_WRITE);

  always_comb begin
    ctl[0].valid         = s_tvalid;
    ctl[0].op            = op_e_t'(s_tuser);
    ctl[0].entry_index   = s_tdata[5:0];
    ctl[0].entry_present = s_tdata[6];
    ctl[0].rect_disabled = s_tdata[7];
    ctl[0].found         = 1'b0;
    if (is_write) begin
      arg[0][RECT_LEFT]   = C'(s_tdata[23:8]);
      arg[0][RECT_TOP]    = C'(s_tdata[39:24]);
      arg[0][RECT_WIDTH]  = C'(s_tdata[55:40]);
      arg[0][RECT_HEIGHT] = C'(s_tdata[71:56]);
    end else begin
      arg[0][SEG_POS]     = C'(s_tdata[87:72]);
      arg[0][SEG_START]   = C'(s_tdata[103:88]);
      arg[0][SEG_END]     = C'(s_tdata[119:104]);
      arg[0][RECT_HEIGHT] = '0;
    end
    best[0]     = '0;
    best_idx[0] = '0;
  end

  // One cell per table slot.
  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    roq_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CELL_ID    (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .in_ctl       (ctl[i]),
      .in_arg       (arg[i]),
      .in_best      (best[i]),
      .in_best_idx  (best_idx[i]),
      .out_ctl      (ctl[i+1]),
      .out_arg      (arg[i+1]),
      .out_best     (best[i+1]),
      .out_best_idx (best_idx[i+1])
    );
  end

  // The last cell's register is the result beat.
  assign m_tvalid   = ctl[MAX_RECTS].valid;
  assign m_tuser[0] = ctl[MAX_RECTS].found;
  assign m_tdata    = {2'b00,
                       FIELD_W'(best[MAX_RECTS][RECT_HEIGHT]),
                       FIELD_W'(best[MAX_RECTS][RECT_WIDTH]),
                       FIELD_W'(best[MAX_RECTS][RECT_TOP]),
                       FIELD_W'(best[MAX_RECTS][RECT_LEFT]),
                       ENTRY_IDX_W'(best_idx[MAX_RECTS])};

endmodule

FILE: test/rect_obstacle_query_tb.sv
import roq_pkg::*;

// One stored rectangle as the table keeps it.
typedef struct packed {
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] width;
  logic [15:0] height;
} obstacle_t;

// Expected answer to one input beat.
typedef struct packed {
  logic      found;
  logic [5:0] index;
  obstacle_t rect;
} blocker_t;

// Input beat payload, laid out as on s_tdata (index in the lowest bits).
typedef struct packed {
  logic [15:0] seg_end;
  logic [15:0] seg_start;
  logic [15:0] line_pos;
  logic [15:0] height;
  logic [15:0] width;
  logic [15:0] top;
  logic [15:0] left;
  logic        disabled;
  logic        present;
  logic [5:0]  index;
} item_data_t;

// Shadow copy of the obstacle table plus the queue of answers still owed.
class obstacle_board;
  obstacle_t   rects[64];
  bit          present[64];
  bit          disabled[64];
  blocker_t    expected_hits[$];
  int unsigned errors;
  int unsigned writes;
  int unsigned removals;
  int unsigned queries;
  int unsigned hits;
  int unsigned ignored;

  function new();
    foreach (present[i]) begin
      present[i]  = 1'b0;
      disabled[i] = 1'b0;
      rects[i]    = '0;
    end
  endfunction

  // Does rectangle r stand in the way of the segment for this direction?
  function bit blocks(logic [2:0] op, obstacle_t r, logic [15:0] p, logic [15:0] s,
                      logic [15:0] e);
    logic [16:0] right;
    logic [16:0] bottom;
    right  = {1'b0, r.left} + {1'b0, r.width};
    bottom = {1'b0, r.top} + {1'b0, r.height};
    case (op)
      OP_WEST:  return r.left < s && right > e && r.top < p && bottom > p;
      OP_EAST:  return r.left < e && right > s && r.top < p && bottom > p;
      OP_SOUTH: return bottom > s && r.top < e && r.left < p && right > p;
      OP_NORTH: return r.top < s && bottom > e && r.left < p && right > p;
      default:  return 1'b0;
    endcase
  endfunction

  // Strictly closer along the direction of travel; ties keep the lower slot.
  function bit closer(logic [2:0] op, obstacle_t c, obstacle_t b);
    case (op)
      OP_WEST:  return ({1'b0, c.left} + {1'b0, c.width}) > ({1'b0, b.left} + {1'b0, b.width});
      OP_EAST:  return c.left < b.left;
      OP_SOUTH: return c.top < b.top;
      OP_NORTH: return ({1'b0, c.top} + {1'b0, c.height}) > ({1'b0, b.top} + {1'b0, b.height});
      default:  return 1'b0;
    endcase
  endfunction

  function blocker_t find_blocker(logic [2:0] op, item_data_t d);
    blocker_t best;
    best = '0;
    for (int i = 0; i < 64; i++) begin
      if (!present[i] || disabled[i]) continue;
      if (!blocks(op, rects[i], d.line_pos, d.seg_start, d.seg_end)) continue;
      if (!best.found || closer(op, rects[i], best.rect)) begin
        best.found = 1'b1;
        best.index = i[5:0];
        best.rect  = rects[i];
      end
    end
    return best;
  endfunction

  // Apply an accepted input beat to the table and queue its answer.
  function void note_beat(logic [2:0] op, item_data_t d);
    blocker_t answer;
    answer = '0;
    if (op == OP_WRITE) begin
      writes++;
      if (d.present) begin
        rects[d.index]    = '{d.left, d.top, d.width, d.height};
        disabled[d.index] = d.disabled;
        present[d.index]  = 1'b1;
      end else begin
        removals++;
        present[d.index] = 1'b0;
      end
    end else if (op inside {OP_WEST, OP_EAST, OP_SOUTH, OP_NORTH}) begin
      queries++;
      answer = find_blocker(op, d);
      if (answer.found) hits++;
    end else begin
      ignored++;
    end
    expected_hits.push_back(answer);
  endfunction

  function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      errors++;
    end
  endfunction

  // Compare one result beat with the oldest answer owed.
  function void check_beat(logic [71:0] data, logic found);
    blocker_t exp;
    if (expected_hits.size() == 0) begin
      $error("result beat with no item outstanding: tdata %h found %b", data, found);
      errors++;
      return;
    end
    exp = expected_hits.pop_front();
    compare_field("found", 32'(exp.found), 32'(found));
    compare_field("hit_index", 32'(exp.index), 32'(data[5:0]));
    compare_field("hit_left", 32'(exp.rect.left), 32'(data[21:6]));
    compare_field("hit_top", 32'(exp.rect.top), 32'(data[37:22]));
    compare_field("hit_width", 32'(exp.rect.width), 32'(data[53:38]));
    compare_field("hit_height", 32'(exp.rect.height), 32'(data[69:54]));
  endfunction
endclass

module rect_obstacle_query_tb;

  localparam int          ROW_DEPTH     = 64;
  localparam int          RANDOM_ITEMS  = 650;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          STALL_LIMIT   = 2000;
  localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  OP_RSVD_MID   = 3'd6;
  localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;
  logic [0:0]   m_tuser;

  obstacle_board board;
  bit            steady;
  bit            hold_req;
  logic [15:0]   window_base;
  int unsigned   quiet_cycles;

  rect_obstacle_query u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one beat from a falling edge and hold it until it is taken.
  task automatic send_item(input logic [2:0] op, input item_data_t d);
    while (!steady && $urandom_range(0, 99) < 6) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = d;
    do @(posedge clk); while (!s_tready);
    board.note_beat(op, d);
    @(negedge clk);
  endtask

  task automatic write_rect(input int idx, input bit keep, input bit off,
                            input int l, input int t, input int w, input int h);
    item_data_t d;
    d          = '0;
    d.index    = idx[5:0];
    d.present  = keep;
    d.disabled = off;
    d.left     = l[15:0];
    d.top      = t[15:0];
    d.width    = w[15:0];
    d.height   = h[15:0];
    send_item(OP_WRITE, d);
  endtask

  task automatic query(input logic [2:0] op, input int p, input int s, input int e);
    item_data_t d;
    d           = '0;
    d.line_pos  = p[15:0];
    d.seg_start = s[15:0];
    d.seg_end   = e[15:0];
    send_item(op, d);
  endtask

  // Mostly coordinates in a small window so that rectangles and segments meet.
  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 99) < 15) return 16'($urandom_range(0, 65535));
    return window_base + 16'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_size();
    if ($urandom_range(0, 99) < 10) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 96));
  endfunction

  // Receiver: random stalls, a steady stretch, and one long hold-off.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready  = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready = steady || $urandom_range(0, 99) >= 6;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser[0]);
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("rect_obstacle_query test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    item_data_t  d;
    logic [2:0]  op;
    int unsigned pick;

    board        = new();
    steady       = 1'b0;
    hold_req     = 1'b0;
    window_base  = 16'($urandom_range(0, 65000));
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_WRITE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty table, ties, disabled and removed slots, wide edges.
    query(OP_WEST, 125, 200, 0);
    write_rect(0, 1, 0, 100, 100, 50, 50);
    write_rect(5, 1, 0, 100, 100, 50, 50);
    write_rect(10, 1, 1, 0, 0, 65535, 65535);
    write_rect(20, 1, 0, 0, 120, 10, 10);
    write_rect(30, 1, 0, 300, 120, 0, 10);
    write_rect(62, 1, 0, 65534, 65534, 65535, 65535);
    write_rect(63, 1, 0, 65535, 65535, 65535, 65535);
    query(OP_WEST, 125, 200, 0);
    query(OP_EAST, 125, 0, 200);
    query(OP_EAST, 125, 250, 400);
    query(OP_SOUTH, 125, 0, 200);
    query(OP_NORTH, 125, 200, 0);
    query(OP_WEST, 65535, 65535, 65535);
    query(OP_NORTH, 65535, 65535, 65535);
    query(OP_RSVD_FIRST, 125, 200, 0);
    query(OP_RSVD_MID, 125, 0, 200);
    query(OP_RSVD_LAST, 125, 0, 200);
    // The removed slot keeps its rectangle but no longer takes part.
    write_rect(0, 0, 0, 0, 0, 0, 0);
    query(OP_WEST, 125, 200, 0);
    write_rect(10, 1, 0, 0, 0, 1, 1);
    write_rect(20, 0, 1, 65535, 65535, 65535, 65535);
    query(OP_EAST, 125, 0, 200);
    write_rect(10, 0, 0, 0, 0, 0, 0);

    // Random part: table writes, queries and stray ops over a shared window.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 250 && n < 400);
      if (n == 450) hold_req = 1'b1;
      d.index     = 6'($urandom_range(0, 63));
      d.present   = $urandom_range(0, 99) >= 15;
      d.disabled  = $urandom_range(0, 99) < 15;
      d.left      = pick_coord();
      d.top       = pick_coord();
      d.width     = pick_size();
      d.height    = pick_size();
      d.line_pos  = pick_coord();
      d.seg_start = pick_coord();
      d.seg_end   = pick_coord();
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_WRITE;
      else if (pick < 92) op = 3'($urandom_range(OP_WEST, OP_NORTH));
      else op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      send_item(op, d);
    end
    s_tvalid = 1'b0;
    steady   = 1'b0;

    // Drain, then give the row time to show any stray beat.
    while (board.expected_hits.size() != 0) @(posedge clk);
    repeat (ROW_DEPTH + 16) @(posedge clk);

    $display("Covered %0d table writes (%0d removals), %0d queries with %0d hits,",
             board.writes, board.removals, board.queries, board.hits);
    $display("%0d unknown ops, and one %0d-cycle output hold-off with the row full.",
             board.ignored, HOLD_CYCLES);
    if (board.errors == 0 && board.expected_hits.size() == 0) begin
      $display("rect_obstacle_query test passed");
    end else begin
      $display("rect_obstacle_query test failed");
    end
    $finish;
  end

endmodule

FILE: rect_obstacle_query.f
rtl/core/roq_pkg.sv
rtl/core/roq_cell.sv
rtl/core/rect_obstacle_query.sv
test/rect_obstacle_query_tb.sv
